// ===== src/face_corner_vertex_dedup_assert.svh =====
// Assertion macros for the face corner vertex dedup block.
// Included by the top-level RTL file, which carries the concurrent assertions; no other dependencies.
`ifndef FACE_CORNER_VERTEX_DEDUP_ASSERT_SVH
`define FACE_CORNER_VERTEX_DEDUP_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while the block is out of reset.
`define FCVD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fcvd assertion failed")

// Checked at every clock edge, reset included.
`define FCVD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fcvd assertion failed")

`else

`define FCVD_ASSERT(lbl, clk, rst_n, prop)
`define FCVD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/fcvd_pkg.sv =====
// Package for the face corner vertex dedup block: sizes, codes and payload types.
// Used by every module of the block but fcvd_ram; depends on nothing else.
package fcvd_pkg;

    localparam int MAX_VERTS = 4096;
    localparam int SLOT_AW   = $clog2(MAX_VERTS);
    localparam int IDX_W     = 15;
    localparam int VC_W      = 13;
    localparam int CNT_W     = 17;
    localparam int OUT_IDX_W = 16;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [OUT_IDX_W-1:0] INDEX_LIMIT = '1;

    // Register index, taken from paddr above the byte offset.
    localparam logic [ADDR_W-3:0] REG_VERTEX_COUNT = '0;

    typedef enum logic [1:0] {
        OUTCOME_FIRST_USE    = 2'd0,
        OUTCOME_MATCHED      = 2'd1,
        OUTCOME_APPENDED     = 2'd2,
        OUTCOME_OUT_OF_RANGE = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [IDX_W-1:0] position_index;
        logic [IDX_W-1:0] normal_index;
        logic [IDX_W-1:0] texture_index;
    } t_corner;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] combined_index;
        logic [1:0]           outcome;
        logic                 overflow;
    } t_result;

    typedef struct packed {
        logic             used;
        logic [IDX_W-1:0] normal_index;
        logic [IDX_W-1:0] texture_index;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef struct packed {
        logic [VC_W-1:0] vertex_count;
        logic            reload;
    } t_cfg;

    typedef struct packed {
        logic               active;
        logic [SLOT_AW-1:0] addr;
    } t_sweep;

endpackage

// ===== src/fcvd_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependencies.
module fcvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fcvd_regs.sv =====
// APB-style configuration register file holding vertex_count.
// Depends on fcvd_pkg for widths, the register index and the t_cfg type.
module fcvd_regs
    import fcvd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [VC_W-1:0]   r_vertex_count;
    logic [VC_W-1:0]   n_vertex_count;
    logic [ADDR_W-3:0] reg_idx;
    logic              wr_access;
    logic              r_reload;
    logic              n_reload;

    assign reg_idx   = paddr[ADDR_W-1:2];
    assign wr_access = psel && penable && pwrite;

    always_comb begin
        n_vertex_count = r_vertex_count;
        n_reload       = 1'b0;
        prdata         = '0;
        unique case (reg_idx)
            REG_VERTEX_COUNT: begin
                prdata = DATA_W'(r_vertex_count);
                if (wr_access) begin
                    n_vertex_count = pwdata[VC_W-1:0];
                    n_reload       = 1'b1;
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // The reload pulse is registered together with the new vertex_count, so the counter takes the new count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_reload       <= 1'b0;
        end else begin
            r_vertex_count <= n_vertex_count;
            r_reload       <= n_reload;
        end
    end

    assign pready              = 1'b1;
    assign o_cfg.vertex_count  = r_vertex_count;
    assign o_cfg.reload        = r_reload;

endmodule

// ===== src/fcvd_sweep.sv =====
// Clearing sweep that writes every slot of the table to unused after reset.
// Depends on fcvd_pkg for the table size and the t_sweep type.
module fcvd_sweep
    import fcvd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    output t_sweep o_sweep
);

    logic               r_active;
    logic [SLOT_AW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_addr   <= '0;
        end else if (r_active) begin
            r_addr <= r_addr + 1'b1;
            if (r_addr == SLOT_AW'(MAX_VERTS - 1)) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_sweep.active = r_active;
    assign o_sweep.addr   = r_addr;

endmodule

// ===== src/face_corner_vertex_dedup.sv =====
// Top level of the face corner vertex dedup block: lookup stage, append counter, result register.
// Depends on fcvd_pkg, fcvd_ram, fcvd_regs, fcvd_sweep and the assertion macro header.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------
//  corner   | in        | i_in_valid / o_in_ready    | i_in_data  (t_corner)
//  result   | out       | o_out_valid / i_out_ready  | o_out_data (t_result)
//  config   | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// Each corner is handled first by the slot read from the table RAM, then by the decision, which
// writes the slot back and loads the result register; a new corner is taken only after that load.
// After reset a sweep clears the 4096-entry table, one entry per cycle; no corner is taken
// until the sweep ends, while configuration writes are taken as usual.
// A full result register that is not taken holds the corner in the lookup stage.
`include "face_corner_vertex_dedup_assert.svh"

module face_corner_vertex_dedup
    import fcvd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_corner           i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_result           o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_sweep  sweep;

    t_corner r_item;
    logic    r_in_range;
    logic    r_busy;
    logic    n_busy;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out_data;
    t_result n_out_data;
    logic [CNT_W-1:0] r_next;
    logic [CNT_W-1:0] n_next;

    logic               accept_in;
    logic               finish;
    logic               in_range;
    logic               first_use;
    logic               ram_we;
    logic [SLOT_AW-1:0] ram_waddr;
    t_slot              ram_wdata;
    logic [SLOT_W-1:0]  ram_rdata;
    t_slot              slot;

    fcvd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fcvd_sweep u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_sweep (sweep)
    );

    fcvd_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_VERTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept_in),
        .i_raddr (i_in_data.position_index[SLOT_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign slot = t_slot'(ram_rdata);

    assign o_in_ready = !sweep.active && !r_busy;
    assign accept_in  = i_in_valid && o_in_ready;
    assign finish     = r_busy && (!r_out_valid || i_out_ready);

    // A position must lie below both the configured count and the table size.
    assign in_range = (i_in_data.position_index < IDX_W'(cfg.vertex_count))
                   && ({1'b0, i_in_data.position_index} < 16'(MAX_VERTS));

    always_comb begin
        n_out_data = r_out_data;
        n_next     = r_next;
        first_use  = 1'b0;
        if (finish) begin
            n_out_data.overflow       = 1'b0;
            n_out_data.combined_index = OUT_IDX_W'(r_item.position_index);
            if (!r_in_range) begin
                n_out_data.outcome        = OUTCOME_OUT_OF_RANGE;
                n_out_data.combined_index = '0;
            end else if (!slot.used) begin
                n_out_data.outcome = OUTCOME_FIRST_USE;
                first_use          = 1'b1;
            end else if (slot.normal_index == r_item.normal_index
                         && slot.texture_index == r_item.texture_index) begin
                n_out_data.outcome = OUTCOME_MATCHED;
            end else begin
                n_out_data.outcome = OUTCOME_APPENDED;
                if (r_next[CNT_W-1]) begin
                    n_out_data.combined_index = INDEX_LIMIT;
                    n_out_data.overflow       = 1'b1;
                end else begin
                    n_out_data.combined_index = r_next[OUT_IDX_W-1:0];
                    n_next                    = r_next + 1'b1;
                end
            end
        end
        if (cfg.reload) begin
            n_next = CNT_W'(cfg.vertex_count);
        end
    end

    always_comb begin
        ram_we    = sweep.active || first_use;
        ram_waddr = r_item.position_index[SLOT_AW-1:0];
        ram_wdata.used          = 1'b1;
        ram_wdata.normal_index  = r_item.normal_index;
        ram_wdata.texture_index = r_item.texture_index;
        if (sweep.active) begin
            ram_waddr = sweep.addr;
            ram_wdata = '0;
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (accept_in) begin
            n_busy = 1'b1;
        end else if (finish) begin
            n_busy = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_next      <= '0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_next      <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_item     <= i_in_data;
            r_in_range <= in_range;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `FCVD_ASSERT(a_lookup_not_during_sweep, i_clk, i_rst_n, r_busy |-> !sweep.active);
    `FCVD_ASSERT(a_stall_holds_item, i_clk, i_rst_n,
        (r_busy && !finish) |=> (r_busy && $stable(r_item)));
    `FCVD_ASSERT(a_overflow_only_saturated, i_clk, i_rst_n,
        (o_out_valid && o_out_data.overflow) |->
            (o_out_data.outcome == OUTCOME_APPENDED
             && o_out_data.combined_index == INDEX_LIMIT));
    `FCVD_ASSERT(a_counter_monotonic, i_clk, i_rst_n,
        !cfg.reload |=> (r_next >= $past(r_next)));
    `FCVD_ASSERT(a_slot_write_in_lookup, i_clk, i_rst_n,
        (ram_we && !sweep.active) |-> finish);

endmodule
